FILE: hw/rtl/pbp_pkg.sv
// Shared types, constants and helpers for the pixel border painter.
`default_nettype none

package pbp_pkg;

   localparam int MAX_DIM = 4096;
   localparam int DIM_W   = $clog2(MAX_DIM) + 1;  // holds MAX_DIM itself
   localparam int POS_W   = $clog2(MAX_DIM);      // column and row counters
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CHAN_W     = 3;

   localparam logic [CHAN_W-1:0] CHAN_MONO = 3'd1;
   localparam logic [CHAN_W-1:0] CHAN_BGR  = 3'd3;
   localparam logic [CHAN_W-1:0] CHAN_BGRA = 3'd4;
   localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_SOURCE_CHANNELS = 3'd2,
      CSR_BORDER_WIDTH    = 3'd3,
      CSR_PAINT_COLOR     = 3'd4,
      CSR_INSERT_ALPHA    = 3'd5,
      CSR_BORDER_BGRA     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] border;
   } geometry_type;

   typedef struct packed {
      logic in_band;
      logic last;
   } position_type;

   // Force a size register into 1..MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      begin
         r = v;
         if (v == '0) begin
            r = DIM_W'(1);
         end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
         end
         return r;
      end
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pbp_position.sv
// Column/row tracker and border band test for the pixel border painter.
`default_nettype none

module pbp_position (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire pbp_pkg::geometry_type geometry,
   output pbp_pkg::position_type      pos
);

   logic [pbp_pkg::POS_W-1:0] column_ff, column_in;
   logic [pbp_pkg::POS_W-1:0] row_ff, row_in;

   logic [pbp_pkg::DIM_W-1:0] w, h, bw, bx, by;
   logic [pbp_pkg::DIM_W-1:0] col_x, row_x, col_inc, row_inc;

   always_comb begin
      w  = pbp_pkg::clamp_dim(geometry.width);
      h  = pbp_pkg::clamp_dim(geometry.height);
      bw = (geometry.border == '0) ? pbp_pkg::DIM_W'(1) : geometry.border;
      bx = (bw < w) ? bw : w;
      by = (bw < h) ? bw : h;

      col_x   = {1'b0, column_ff};
      row_x   = {1'b0, row_ff};
      col_inc = col_x + pbp_pkg::DIM_W'(1);
      row_inc = row_x + pbp_pkg::DIM_W'(1);

      pos.in_band = (row_x < by) || (row_x >= h - by) ||
                    (col_x < bx) || (col_x >= w - bx);
      pos.last    = (col_x == w - pbp_pkg::DIM_W'(1)) &&
                    (row_x == h - pbp_pkg::DIM_W'(1));

      // Wrap at end of row; a row left past a shrunken height drops to zero.
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (col_inc >= w) begin
            column_in = '0;
            row_in    = (row_inc >= h) ? '0 : row_inc[pbp_pkg::POS_W-1:0];
         end else begin
            column_in = col_inc[pbp_pkg::POS_W-1:0];
            if (row_x >= h) begin
               row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_border_painter.sv
// Top level of the pixel border painter: config registers, pipeline and pixel formatting.
//
// Usage:
//   Pixels arrive in raster order on the req_ channel (valid/ready), one
//   pixel of 1 to 4 bytes per transfer on req_byte_0..req_byte_3. Each
//   accepted pixel yields exactly one result pixel on the rsp_ channel.
//   The csr_ port writes the seven settings (size, source channel count,
//   border width, paint and alpha enables, border color); write it only
//   while no pixel is in flight.
//   A pixel accepted on req_ is registered in the position stage, then in the
//   result register, and is offered on rsp_. Throughput: one pixel per cycle
//   while rsp_ready is high, set by the two pipeline registers (position stage,
//   then format/paint stage), each of which refills in the cycle it is drained.
//   Stall: when rsp_ready is low the result register holds, the position
//   stage fills behind it, and then req_ready drops until the result is
//   taken. No pixel is dropped or repeated.
//   Reset: empties both stages, restarts at column 0, row 0, and loads
//   width 1, height 1, four channels, border 1, painting off, alpha off.
//   rsp_frame_last marks the final pixel of each image.
`default_nettype none

module pixel_border_painter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // pixel input
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_byte_0,
   input  wire logic [7:0]                       req_byte_1,
   input  wire logic [7:0]                       req_byte_2,
   input  wire logic [7:0]                       req_byte_3,
   // pixel output
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_out_blue,
   output logic [7:0]                            rsp_out_green,
   output logic [7:0]                            rsp_out_red,
   output logic [7:0]                            rsp_out_alpha,
   output logic [pbp_pkg::CHAN_W-1:0]            rsp_out_channels,
   output logic                                  rsp_frame_last,
   // configuration writes
   input  wire logic                             csr_write_enable,
   input  wire logic [pbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pbp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [pbp_pkg::DIM_W-1:0]  image_width_ff;
   logic [pbp_pkg::DIM_W-1:0]  image_height_ff;
   logic [pbp_pkg::CHAN_W-1:0] source_channels_ff;
   logic [pbp_pkg::DIM_W-1:0]  border_width_ff;
   logic                       paint_color_ff;
   logic                       insert_alpha_ff;
   logic [31:0]                border_bgra_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff     <= pbp_pkg::DIM_W'(1);
         image_height_ff    <= pbp_pkg::DIM_W'(1);
         source_channels_ff <= pbp_pkg::CHAN_BGRA;
         border_width_ff    <= pbp_pkg::DIM_W'(1);
         paint_color_ff     <= 1'b0;
         insert_alpha_ff    <= 1'b0;
         border_bgra_ff     <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pbp_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[pbp_pkg::DIM_W-1:0];
            end
            pbp_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[pbp_pkg::DIM_W-1:0];
            end
            pbp_pkg::CSR_SOURCE_CHANNELS: begin
               source_channels_ff <= csr_wdata[pbp_pkg::CHAN_W-1:0];
            end
            pbp_pkg::CSR_BORDER_WIDTH: begin
               border_width_ff <= csr_wdata[pbp_pkg::DIM_W-1:0];
            end
            pbp_pkg::CSR_PAINT_COLOR: begin
               paint_color_ff <= csr_wdata[0];
            end
            pbp_pkg::CSR_INSERT_ALPHA: begin
               insert_alpha_ff <= csr_wdata[0];
            end
            pbp_pkg::CSR_BORDER_BGRA: begin
               border_bgra_ff <= csr_wdata[31:0];
            end
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: each stage refills when empty or when it drains this cycle
   // ---------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_ready;
   logic s1_ready;
   logic req_xfer;
   logic s1_xfer;

   assign s2_ready  = !rsp_valid || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign req_xfer  = req_valid && s1_ready;
   assign s1_xfer   = s1_valid_ff && s2_ready;

   // ---------------------------------------------------------------
   // Stage 1: position in the frame, captured with the raw bytes
   // ---------------------------------------------------------------
   pbp_pkg::geometry_type geometry;
   pbp_pkg::position_type pos;

   assign geometry.width  = image_width_ff;
   assign geometry.height = image_height_ff;
   assign geometry.border = border_width_ff;

   pbp_position u_position (
      .clock    (clock),
      .reset    (reset),
      .advance  (req_xfer),
      .geometry (geometry),
      .pos      (pos)
   );

   logic [3:0][7:0] s1_bytes_ff;
   logic            s1_in_band_ff;
   logic            s1_last_ff;

   assign s1_valid_in = req_xfer || (s1_valid_ff && !s2_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_bytes_ff   <= {req_byte_3, req_byte_2, req_byte_1, req_byte_0};
         s1_in_band_ff <= pos.in_band;
         s1_last_ff    <= pos.last;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: channel formatting, alpha insertion and border paint
   // ---------------------------------------------------------------
   logic [pbp_pkg::CHAN_W-1:0] src_chan;
   logic [pbp_pkg::CHAN_W-1:0] copy_chan;
   logic [pbp_pkg::CHAN_W-1:0] paint_chan;
   logic [pbp_pkg::CHAN_W-1:0] chan_in;
   logic                       widen;
   logic [3:0][7:0]            px_in;

   always_comb begin
      // Zero counts as mono; anything past four counts as BGRA.
      src_chan = source_channels_ff;
      if (source_channels_ff == '0) begin
         src_chan = pbp_pkg::CHAN_MONO;
      end else if (source_channels_ff > pbp_pkg::CHAN_BGRA) begin
         src_chan = pbp_pkg::CHAN_BGRA;
      end

      widen     = insert_alpha_ff && (src_chan != pbp_pkg::CHAN_BGRA);
      copy_chan = (widen && src_chan > pbp_pkg::CHAN_BGR) ? pbp_pkg::CHAN_BGR : src_chan;
      chan_in   = widen ? pbp_pkg::CHAN_BGRA : src_chan;
      paint_chan = (chan_in > pbp_pkg::CHAN_BGR) ? pbp_pkg::CHAN_BGR : chan_in;

      for (int i = 0; i < 4; i++) begin
         px_in[i] = (pbp_pkg::CHAN_W'(i) < copy_chan) ? s1_bytes_ff[i] : 8'h00;
      end
      if (widen) begin
         px_in[3] = pbp_pkg::ALPHA_OPAQUE;
      end

      if (s1_in_band_ff) begin
         if (paint_color_ff) begin
            for (int i = 0; i < 3; i++) begin
               if (pbp_pkg::CHAN_W'(i) < paint_chan) begin
                  px_in[i] = border_bgra_ff[8*i +: 8];
               end
            end
         end
         if (insert_alpha_ff && chan_in == pbp_pkg::CHAN_BGRA) begin
            px_in[3] = border_bgra_ff[31:24];
         end
      end
   end

   // Result register: hold while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_xfer) begin
         rsp_out_blue     <= px_in[0];
         rsp_out_green    <= px_in[1];
         rsp_out_red      <= px_in[2];
         rsp_out_alpha    <= px_in[3];
         rsp_out_channels <= chan_in;
         rsp_frame_last   <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_channels != '0 && rsp_out_channels <= pbp_pkg::CHAN_BGRA))
      else $error("result channel count out of range");

   a_absent_alpha_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_channels != pbp_pkg::CHAN_BGRA) |-> rsp_out_alpha == 8'h00)
      else $error("alpha set on a pixel without an alpha channel");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |-> !req_ready)
      else $error("input accepted while both stages are full");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_bytes_ff)
                                      && $stable(s1_last_ff)))
      else $error("position stage changed while stalled");

endmodule

`default_nettype wire

FILE: tb/pixel_border_painter_tb.sv
// Self-checking testbench for the pixel border painter: directed cases, then randomized frames.
`timescale 1ns / 1ps

module pixel_border_painter_tb;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 3;
   localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
   localparam int LONG_HOLD     = 300;   // one long receiver hold-off
   localparam int PIPE_SETTLE   = 4;     // two pipeline stages plus margin
   localparam int RANDOM_PIXELS = 1300;
   localparam int FINAL_PIXELS  = 100;
   localparam logic [pbp_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam logic [pbp_pkg::DIM_W-1:0]     DIM_FIELD_MAX = '1;

   typedef struct packed {
      logic [7:0]                 blue;
      logic [7:0]                 green;
      logic [7:0]                 red;
      logic [7:0]                 alpha;
      logic [pbp_pkg::CHAN_W-1:0] channels;
      logic                       last;
   } pixel_result_type;

   // ---------------------------------------------------------------------
   // Block pins; every input holds a known value from time zero.
   // ---------------------------------------------------------------------
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   wire logic                      req_ready;
   logic [7:0]                     req_byte_0 = '0;
   logic [7:0]                     req_byte_1 = '0;
   logic [7:0]                     req_byte_2 = '0;
   logic [7:0]                     req_byte_3 = '0;
   wire logic                      rsp_valid;
   logic                           rsp_ready = 1'b0;
   wire logic [7:0]                rsp_out_blue;
   wire logic [7:0]                rsp_out_green;
   wire logic [7:0]                rsp_out_red;
   wire logic [7:0]                rsp_out_alpha;
   wire logic [pbp_pkg::CHAN_W-1:0] rsp_out_channels;
   wire logic                      rsp_frame_last;
   logic                           csr_write_enable = 1'b0;
   logic [pbp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pbp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // ---------------------------------------------------------------------
   // Shadow of the register file and of the raster position. Both start at
   // the values the block loads on reset.
   // ---------------------------------------------------------------------
   logic [pbp_pkg::DIM_W-1:0]  cfg_width    = pbp_pkg::DIM_W'(1);
   logic [pbp_pkg::DIM_W-1:0]  cfg_height   = pbp_pkg::DIM_W'(1);
   logic [pbp_pkg::CHAN_W-1:0] cfg_channels = pbp_pkg::CHAN_BGRA;
   logic [pbp_pkg::DIM_W-1:0]  cfg_border   = pbp_pkg::DIM_W'(1);
   logic                       cfg_paint    = 1'b0;
   logic                       cfg_alpha    = 1'b0;
   logic [31:0]                cfg_bgra     = '0;
   logic [pbp_pkg::POS_W-1:0]  next_column  = '0;
   logic [pbp_pkg::POS_W-1:0]  next_row     = '0;

   pixel_result_type  pixels_due[$];   // painted pixels still owed by the block
   int                mismatch_count = 0;
   bit                sender_idles = 1'b0;
   bit                sink_idles = 1'b0;
   int                long_hold_asks = 0;   // bumped by a test to ask for a long hold
   int                long_hold_taken = 0;  // long holds the receiver has started
   int                stall_left = 0;
   int                quiet_cycles = 0;

   pixel_border_painter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_0       (req_byte_0),
      .req_byte_1       (req_byte_1),
      .req_byte_2       (req_byte_2),
      .req_byte_3       (req_byte_3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_out_channels (rsp_out_channels),
      .rsp_frame_last   (rsp_frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Map a size register onto the range the block actually uses.
   function automatic logic [pbp_pkg::DIM_W-1:0] size_in_use(
         input logic [pbp_pkg::DIM_W-1:0] size);
      if (size == '0) begin
         return pbp_pkg::DIM_W'(1);
      end
      if (size > pbp_pkg::DIM_W'(pbp_pkg::MAX_DIM)) begin
         return pbp_pkg::DIM_W'(pbp_pkg::MAX_DIM);
      end
      return size;
   endfunction

   // Work out the painted pixel for one source pixel, then step the raster
   // position the way the block does, including the wrap when a size
   // register shrank underneath the current position.
   function automatic pixel_result_type predict_painted_pixel(input logic [7:0] b0,
                                                              input logic [7:0] b1,
                                                              input logic [7:0] b2,
                                                              input logic [7:0] b3);
      logic [7:0]                 source [4];
      logic [7:0]                 chan [4];
      logic [pbp_pkg::DIM_W-1:0]  w;
      logic [pbp_pkg::DIM_W-1:0]  h;
      logic [pbp_pkg::DIM_W-1:0]  band;
      logic [pbp_pkg::DIM_W-1:0]  band_x;
      logic [pbp_pkg::DIM_W-1:0]  band_y;
      logic [pbp_pkg::CHAN_W-1:0] src;
      logic [pbp_pkg::CHAN_W-1:0] count;
      logic                       in_band;
      pixel_result_type           r;
      int                         i;

      source[0] = b0;
      source[1] = b1;
      source[2] = b2;
      source[3] = b3;
      w = size_in_use(cfg_width);
      h = size_in_use(cfg_height);

      src = cfg_channels;
      if (src == '0) begin
         src = pbp_pkg::CHAN_MONO;
      end else if (src > pbp_pkg::CHAN_BGRA) begin
         src = pbp_pkg::CHAN_BGRA;
      end

      for (i = 0; i < 4; i++) begin
         chan[i] = 8'h00;
      end
      if (cfg_alpha && src != pbp_pkg::CHAN_BGRA) begin
         // widen to BGRA: at most three color bytes survive, alpha is opaque
         for (i = 0; i < 3; i++) begin
            if (i < src) chan[i] = source[i];
         end
         chan[3] = pbp_pkg::ALPHA_OPAQUE;
         count = pbp_pkg::CHAN_BGRA;
      end else begin
         for (i = 0; i < 4; i++) begin
            if (i < src) chan[i] = source[i];
         end
         count = src;
      end

      band   = (cfg_border == '0) ? pbp_pkg::DIM_W'(1) : cfg_border;
      band_x = (band < w) ? band : w;
      band_y = (band < h) ? band : h;
      in_band = (next_row < band_y) || (next_row >= h - band_y) ||
                (next_column < band_x) || (next_column >= w - band_x);

      if (in_band) begin
         if (cfg_paint) begin
            for (i = 0; i < 3; i++) begin
               if (i < count) chan[i] = cfg_bgra[8*i +: 8];
            end
         end
         if (cfg_alpha && count >= pbp_pkg::CHAN_BGRA) begin
            chan[3] = cfg_bgra[31:24];
         end
      end

      r.blue     = chan[0];
      r.green    = chan[1];
      r.red      = chan[2];
      r.alpha    = chan[3];
      r.channels = count;
      r.last     = (next_column == w - 1) && (next_row == h - 1);

      if (next_column + 1 >= w) begin
         next_column = '0;
         if (next_row + 1 >= h) begin
            next_row = '0;
         end else begin
            next_row = next_row + 1'b1;
         end
      end else begin
         next_column = next_column + 1'b1;
         if (next_row >= h) begin
            next_row = '0;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers. All of them start and end right after a rising edge.
   // ---------------------------------------------------------------------

   // Write one register; the shadow follows at the edge that takes the write.
   task automatic write_register(input logic [pbp_pkg::CSR_IDX_W-1:0] index,
                                 input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= data;
      @(posedge clock);
      case (index)
         pbp_pkg::CSR_IMAGE_WIDTH:     cfg_width    = data[pbp_pkg::DIM_W-1:0];
         pbp_pkg::CSR_IMAGE_HEIGHT:    cfg_height   = data[pbp_pkg::DIM_W-1:0];
         pbp_pkg::CSR_SOURCE_CHANNELS: cfg_channels = data[pbp_pkg::CHAN_W-1:0];
         pbp_pkg::CSR_BORDER_WIDTH:    cfg_border   = data[pbp_pkg::DIM_W-1:0];
         pbp_pkg::CSR_PAINT_COLOR:     cfg_paint    = data[0];
         pbp_pkg::CSR_INSERT_ALPHA:    cfg_alpha    = data[0];
         pbp_pkg::CSR_BORDER_BGRA:     cfg_bgra     = data;
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one pixel, hold it until the transfer, record what must come back,
   // then maybe drop valid for a random burst.
   task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
      int gap;
      req_valid  <= 1'b1;
      req_byte_0 <= b0;
      req_byte_1 <= b1;
      req_byte_2 <= b2;
      req_byte_3 <= b3;
      do @(posedge clock); while (!req_ready);
      pixels_due.push_back(predict_painted_pixel(b0, b1, b2, b3));
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_pixels(input int count);
      repeat (count) send_pixel(random_byte(), random_byte(), random_byte(), random_byte());
   endtask

   // Drop valid and wait until every owed pixel has come back, then let the
   // pipeline settle so a register write finds the block idle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // Sometimes set bits above the register field; the block must ignore them.
   function automatic logic [31:0] with_upper_noise(input logic [31:0] value,
                                                    input logic [31:0] field_mask);
      if ($urandom_range(0, 3) == 0) begin
         return ($urandom & ~field_mask) | value;
      end
      return value;
   endfunction

   function automatic logic [pbp_pkg::DIM_W-1:0] random_size();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return pbp_pkg::DIM_W'(pbp_pkg::MAX_DIM);
         2:       return pbp_pkg::DIM_W'($urandom_range(pbp_pkg::MAX_DIM + 1, DIM_FIELD_MAX));
         3:       return pbp_pkg::DIM_W'($urandom_range(1, pbp_pkg::MAX_DIM));
         default: return pbp_pkg::DIM_W'($urandom_range(1, 12));
      endcase
   endfunction

   // Rewrite a random subset of the registers.
   task automatic randomize_settings();
      logic [31:0] value;
      if ($urandom_range(0, 3) != 0) begin
         write_register(pbp_pkg::CSR_IMAGE_WIDTH,
                        with_upper_noise(32'(random_size()), 32'h1FFF));
      end
      if ($urandom_range(0, 3) != 0) begin
         write_register(pbp_pkg::CSR_IMAGE_HEIGHT,
                        with_upper_noise(32'(random_size()), 32'h1FFF));
      end
      if ($urandom_range(0, 3) != 0) begin
         write_register(pbp_pkg::CSR_SOURCE_CHANNELS,
                        with_upper_noise($urandom_range(0, 7), 32'h7));
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 11))
            0:       value = 32'd0;
            1:       value = 32'(pbp_pkg::MAX_DIM);
            2:       value = 32'(DIM_FIELD_MAX);
            3:       value = $urandom_range(0, DIM_FIELD_MAX);
            default: value = $urandom_range(0, 5);
         endcase
         write_register(pbp_pkg::CSR_BORDER_WIDTH, with_upper_noise(value, 32'h1FFF));
      end
      if ($urandom_range(0, 3) != 0) begin
         write_register(pbp_pkg::CSR_PAINT_COLOR,
                        with_upper_noise($urandom_range(0, 1), 32'h1));
      end
      if ($urandom_range(0, 3) != 0) begin
         write_register(pbp_pkg::CSR_INSERT_ALPHA,
                        with_upper_noise($urandom_range(0, 1), 32'h1));
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 5))
            0:       value = 32'h0000_0000;
            1:       value = 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase
         write_register(pbp_pkg::CSR_BORDER_BGRA, value);
      end
      // an unmapped index must leave every register alone
      if ($urandom_range(0, 7) == 0) begin
         write_register(CSR_UNMAPPED, $urandom);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: check every transfer, stall in random bursts, and take
   // one long hold-off on request.
   // ---------------------------------------------------------------------
   task automatic compare_field(input string field, input logic [7:0] expected,
                                input logic [7:0] actual);
      if (expected !== actual) begin
         $error("%s: expected 0x%02h, got 0x%02h", field, expected, actual);
         mismatch_count++;
      end
   endtask

   task automatic check_pixel();
      pixel_result_type due;
      if (pixels_due.size() == 0) begin
         $error("result pixel with nothing outstanding");
         mismatch_count++;
      end else begin
         due = pixels_due.pop_front();
         compare_field("out_blue", due.blue, rsp_out_blue);
         compare_field("out_green", due.green, rsp_out_green);
         compare_field("out_red", due.red, rsp_out_red);
         compare_field("out_alpha", due.alpha, rsp_out_alpha);
         compare_field("out_channels", 8'(due.channels), 8'(rsp_out_channels));
         compare_field("frame_last", 8'(due.last), 8'(rsp_frame_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_pixel();
         end
         if (long_hold_taken != long_hold_asks) begin
            long_hold_taken = long_hold_asks;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && sink_idles && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset state: 1x1 image, BGRA pass-through, painting off. Every pixel is
   // the whole frame, so frame_last must be set on each.
   task automatic test_reset_defaults();
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      wait_for_drain();
   endtask

   task automatic apply_format(input logic [31:0] channels, input logic [31:0] alpha,
                               input logic [31:0] paint, input logic [31:0] bgra);
      write_register(pbp_pkg::CSR_SOURCE_CHANNELS, channels);
      write_register(pbp_pkg::CSR_INSERT_ALPHA, alpha);
      write_register(pbp_pkg::CSR_PAINT_COLOR, paint);
      write_register(pbp_pkg::CSR_BORDER_BGRA, bgra);
      send_pixel(8'hA5, 8'h3C, 8'hC3, 8'h5A);
      wait_for_drain();
   endtask

   // Each source width from one to four, with alpha widening on for some and off
   // for others; a zero count acts as mono and counts above four act as BGRA.
   task automatic test_channel_formats();
      apply_format(32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF);
      apply_format(32'd2, 32'd1, 32'd0, 32'h1234_5678);
      apply_format(32'd3, 32'd0, 32'd1, 32'h0000_0000);
      apply_format(32'd0, 32'd0, 32'd1, 32'h80C0_E0F0);
      apply_format(32'd7, 32'd1, 32'd1, 32'h5A5A_A5A5);
      apply_format(32'd4, 32'd1, 32'd1, 32'hFFFF_FFFF);
   endtask

   // Zero sizes and a zero border all act as one.
   task automatic test_zero_size();
      write_register(pbp_pkg::CSR_IMAGE_WIDTH, 32'd0);
      write_register(pbp_pkg::CSR_IMAGE_HEIGHT, 32'd0);
      write_register(pbp_pkg::CSR_BORDER_WIDTH, 32'd0);
      send_pixel(8'h01, 8'h80, 8'h7F, 8'hFE);
      wait_for_drain();
   endtask

   // A 3x3 frame with a one-pixel band: only the center stays unpainted.
   task automatic test_small_frame();
      write_register(pbp_pkg::CSR_IMAGE_WIDTH, 32'd3);
      write_register(pbp_pkg::CSR_IMAGE_HEIGHT, 32'd3);
      write_register(pbp_pkg::CSR_BORDER_WIDTH, 32'd1);
      write_register(pbp_pkg::CSR_SOURCE_CHANNELS, 32'd3);
      write_register(pbp_pkg::CSR_INSERT_ALPHA, 32'd0);
      write_register(pbp_pkg::CSR_PAINT_COLOR, 32'd1);
      write_register(pbp_pkg::CSR_BORDER_BGRA, 32'h00FF_00FF);
      send_random_pixels(9);
      wait_for_drain();
   endtask

   // Shrink the sizes under the current position: first the height below the
   // current row, so the row wraps as the column advances, then the width while
   // past its end, so the column wraps onto the next row.
   task automatic test_position_beyond_size();
      write_register(pbp_pkg::CSR_IMAGE_WIDTH, 32'd2);
      write_register(pbp_pkg::CSR_IMAGE_HEIGHT, 32'd4);
      send_random_pixels(4);
      wait_for_drain();
      write_register(pbp_pkg::CSR_IMAGE_WIDTH, 32'd3);
      write_register(pbp_pkg::CSR_IMAGE_HEIGHT, 32'd2);
      send_random_pixels(2);
      wait_for_drain();
      write_register(pbp_pkg::CSR_IMAGE_WIDTH, 32'd1);
      send_random_pixels(1);
      wait_for_drain();
   endtask

   // Sizes above the limit saturate, and a huge border covers everything.
   task automatic test_oversized_image();
      write_register(pbp_pkg::CSR_IMAGE_WIDTH, 32'(DIM_FIELD_MAX));
      write_register(pbp_pkg::CSR_IMAGE_HEIGHT, 32'(pbp_pkg::MAX_DIM + 1));
      write_register(pbp_pkg::CSR_BORDER_WIDTH, 32'(DIM_FIELD_MAX));
      write_register(pbp_pkg::CSR_SOURCE_CHANNELS, 32'd2);
      write_register(pbp_pkg::CSR_INSERT_ALPHA, 32'd1);
      write_register(pbp_pkg::CSR_BORDER_BGRA, 32'hFFFF_FFFF);
      send_random_pixels(2);
      wait_for_drain();
   endtask

   // Hold the result side off for a long stretch while pixels keep coming,
   // so both stages fill and req_ready must drop without losing anything.
   task automatic test_output_backpressure();
      write_register(pbp_pkg::CSR_IMAGE_WIDTH, 32'd7);
      write_register(pbp_pkg::CSR_IMAGE_HEIGHT, 32'd5);
      write_register(pbp_pkg::CSR_BORDER_WIDTH, 32'd2);
      sender_idles = 1'b0;
      long_hold_asks++;
      send_random_pixels(40);
      wait_for_drain();
      sender_idles = 1'b1;
   endtask

   // Stop sending until the pipeline is empty, then resume mid-frame.
   task automatic test_sender_pause();
      send_random_pixels(25);
      wait_for_drain();
      send_random_pixels(25);
      wait_for_drain();
   endtask

   // Random settings per phase; idling on either side switched per phase so
   // some stretches run without gaps.
   task automatic test_random_settings();
      int sent;
      int count;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         randomize_settings();
         sender_idles = ($urandom_range(0, 3) != 0);
         sink_idles   = ($urandom_range(0, 3) != 0);
         count = $urandom_range(10, 90);
         send_random_pixels(count);
         sent += count;
         wait_for_drain();
      end
   endtask

   // Close with a stretch at full rate on both sides.
   task automatic test_full_rate();
      randomize_settings();
      sender_idles = 1'b0;
      sink_idles   = 1'b0;
      send_random_pixels(FINAL_PIXELS);
      wait_for_drain();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_channel_formats();
      test_zero_size();
      test_small_frame();
      test_position_beyond_size();
      test_oversized_image();
      test_output_backpressure();
      test_sender_pause();
      test_random_settings();
      test_full_rate();

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/pbp_pkg.sv
hw/rtl/pbp_position.sv
hw/rtl/pixel_border_painter.sv
tb/pixel_border_painter_tb.sv
